### src/sorted_array_priority_queue_assert.svh
// Assertion macros shared by the sorted array priority queue RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define SAPQ_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define SAPQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/sapq_pkg.sv
// Shared types, codes and helpers of the sorted array priority queue.
// No dependencies; imported by the interfaces, datapath, controller and top level.
package sapq_pkg;

    localparam int SAPQ_DEPTH_DEF = 16;

    localparam int REQ_W = 3;
    localparam int ERR_W = 2;
    localparam int WR_W  = 3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TICK_DUR = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK_DBL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LOOKUP   = 3'd4;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    // Entry RAM write selections
    localparam logic [WR_W-1:0] WR_MOVE_UP   = 3'd0;
    localparam logic [WR_W-1:0] WR_MOVE_DOWN = 3'd1;
    localparam logic [WR_W-1:0] WR_TICK      = 3'd2;
    localparam logic [WR_W-1:0] WR_NEW_NEXT  = 3'd3;
    localparam logic [WR_W-1:0] WR_NEW_ZERO  = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [7:0]         entry_key;
        logic signed [7:0]  entry_duration;
        logic signed [7:0]  entry_durability;
        logic [15:0]        entry_price;
    } t_req;

    typedef struct packed {
        logic               head_valid;
        logic [7:0]         head_key;
        logic signed [7:0]  head_duration;
        logic signed [7:0]  head_durability;
        logic [15:0]        head_price;
        logic               key_found;
        logic [4:0]         entry_count;
        logic [ERR_W-1:0]   error_code;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  key;
        logic [7:0]  duration;
        logic [7:0]  durability;
        logic [15:0] price;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic             latch;
        logic             set_err;
        logic [ERR_W-1:0] err_code;
        logic             idx_inc;
        logic             idx_dec;
        logic             wr_en;
        logic [WR_W-1:0]  wr_sel;
        logic             cap_head;
        logic             set_found;
        logic             cnt_inc;
        logic             cnt_dec;
        logic             out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             empty;
        logic             full;
        logic             last;
        logic             idx_zero;
        logic             key_gt;
        logic             key_eq;
        logic             out_busy;
        logic [REQ_W-1:0] req_type;
    } t_stat;

    // Decrement a countdown, holding at the most negative value
    function automatic logic [7:0] sat_dec(input logic [7:0] v);
        return (v == 8'h80) ? v : v - 8'd1;
    endfunction

endpackage

### src/sapq_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on sapq_pkg for the payload types.
interface sapq_req_if import sapq_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sapq_rsp_if import sapq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/sapq_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sapq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

### src/sapq_datapath.sv
// Datapath: request and result registers, index, occupancy, entry RAM, output register.
// Depends on sapq_pkg, sapq_ram and the assertion macro header.
`include "sorted_array_priority_queue_assert.svh"

module sapq_datapath import sapq_pkg::*; #(
    parameter int DEPTH = SAPQ_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req_data,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_rsp_valid,
    output t_rsp  o_rsp_data,
    input  logic  i_rsp_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $bits(t_entry);

    t_req             r_req;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    n_idx;
    logic [CW-1:0]    r_count;
    t_entry           r_head;
    logic             r_head_valid;
    logic             r_found;
    logic [ERR_W-1:0] r_err;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [AW-1:0]    wr_addr;
    t_entry           wr_data;
    t_entry           rd_data;
    t_entry           new_entry;
    logic [CW+4:0]    cnt_ext;

    // Next index; the RAM reads at it so data for r_idx arrives each cycle
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.latch) begin
            n_idx = (i_req_data.req_type == REQ_INSERT) ? AW'(r_count - CW'(1)) : '0;
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - AW'(1);
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + AW'(1);
        end
    end

    assign new_entry.key        = r_req.entry_key;
    assign new_entry.duration   = r_req.entry_duration;
    assign new_entry.durability = r_req.entry_durability;
    assign new_entry.price      = r_req.entry_price;

    // Select write address and data
    always_comb begin
        wr_addr = r_idx;
        wr_data = rd_data;
        case (i_cmd.wr_sel)
            WR_MOVE_UP: begin
                wr_addr = r_idx + AW'(1);
            end
            WR_MOVE_DOWN: begin
                wr_addr = r_idx - AW'(1);
            end
            WR_TICK: begin
                if (r_req.req_type == REQ_TICK_DUR) begin
                    wr_data.duration = sat_dec(rd_data.duration);
                end else begin
                    wr_data.durability = sat_dec(rd_data.durability);
                end
            end
            WR_NEW_NEXT: begin
                wr_addr = r_idx + AW'(1);
                wr_data = new_entry;
            end
            WR_NEW_ZERO: begin
                wr_addr = '0;
                wr_data = new_entry;
            end
            default: begin
                wr_addr = r_idx;
                wr_data = rd_data;
            end
        endcase
    end

    sapq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_data)
    );

    // Request, index and result registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.latch) begin
            r_req        <= i_req_data;
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_found      <= 1'b0;
            r_err        <= i_cmd.set_err ? i_cmd.err_code : ERR_OK;
        end else begin
            if (i_cmd.cap_head) begin
                r_head       <= rd_data;
                r_head_valid <= 1'b1;
            end
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
        end
    end

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign cnt_ext = {5'd0, r_count};

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.head_valid      <= r_head_valid;
            r_out.head_key        <= r_head.key;
            r_out.head_duration   <= r_head.duration;
            r_out.head_durability <= r_head.durability;
            r_out.head_price      <= r_head.price;
            r_out.key_found       <= r_found;
            r_out.entry_count     <= cnt_ext[4:0];
            r_out.error_code      <= r_err;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_data  = r_out;

    // Status
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.last     = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_stat.idx_zero = (r_idx == '0);
    assign o_stat.key_gt   = (rd_data.key > r_req.entry_key);
    assign o_stat.key_eq   = (rd_data.key == r_req.entry_key);
    assign o_stat.out_busy = r_out_valid && !i_rsp_ready;
    assign o_stat.req_type = r_req.req_type;

    `SAPQ_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "occupancy above depth")
    `SAPQ_ASSERT_SAME(a_inc_not_full, i_cmd.cnt_inc, !o_stat.full, "insert into full table")
    `SAPQ_ASSERT_SAME(a_dec_not_empty, i_cmd.cnt_dec, !o_stat.empty, "remove from empty table")
    `SAPQ_ASSERT_NEXT(a_one_at_a_time, i_cmd.latch, !i_cmd.latch, "request taken while busy")

endmodule

### src/sapq_ctrl.sv
// Controller: sequences insert, remove, tick and lookup over the entry RAM.
// Depends on sapq_pkg; drives the datapath through t_cmd and reads t_stat.
module sapq_ctrl import sapq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_req_ready,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DONE;
                    case (i_req_type)
                        REQ_INSERT: begin
                            if (i_stat.full) begin
                                o_cmd.set_err  = 1'b1;
                                o_cmd.err_code = ERR_FULL;
                            end else if (i_stat.empty) begin
                                n_state = S_PUT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        REQ_REMOVE: begin
                            if (i_stat.empty) begin
                                o_cmd.set_err  = 1'b1;
                                o_cmd.err_code = ERR_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        REQ_TICK_DUR, REQ_TICK_DBL, REQ_LOOKUP: begin
                            if (!i_stat.empty) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                case (i_stat.req_type)
                    REQ_INSERT: begin
                        o_cmd.wr_en = 1'b1;
                        if (i_stat.key_gt) begin
                            // shift this entry up one slot and keep walking down; at slot zero go on to S_PUT
                            o_cmd.wr_sel = WR_MOVE_UP;
                            if (i_stat.idx_zero) begin
                                n_state = S_PUT;
                            end else begin
                                o_cmd.idx_dec = 1'b1;
                            end
                        end else begin
                            o_cmd.wr_sel  = WR_NEW_NEXT;
                            o_cmd.cnt_inc = 1'b1;
                            n_state       = S_DONE;
                        end
                    end
                    REQ_REMOVE: begin
                        if (i_stat.idx_zero) begin
                            o_cmd.cap_head = 1'b1;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_MOVE_DOWN;
                        end
                        if (i_stat.last) begin
                            o_cmd.cnt_dec = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                    REQ_TICK_DUR, REQ_TICK_DBL: begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = WR_TICK;
                        if (i_stat.last) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                    REQ_LOOKUP: begin
                        if (i_stat.key_eq) begin
                            o_cmd.set_found = 1'b1;
                            n_state         = S_DONE;
                        end else if (i_stat.last) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PUT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_NEW_ZERO;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/sorted_array_priority_queue.sv
// Top level of the sorted array priority queue: controller, datapath and channel ports.
// Depends on sapq_pkg, sapq_if, sapq_ctrl and sapq_datapath.
//
// Usage:
//   i_req carries one request transaction (insert, remove head, tick duration,
//   tick durability, lookup); o_rsp returns exactly one response transaction
//   for each, in order, with the removed head, the lookup result, the entry
//   count after the request and an error code (insert while full, remove while
//   empty).
//   Requests are handled one at a time. Entries live in a RAM with one read
//   and one write port; a request walks it one entry per cycle. The shortest
//   path (an error, a tick or lookup on an empty table, or an unused code) goes
//   straight to the done state; the longest is a walk over a full table, or an
//   insert at the front of a table holding DEPTH - 1 entries. The next request
//   is taken once the response is registered.
//   The response sits in an output register; while the receiver stalls, the
//   block still takes and finishes one more request, holds its response until
//   the register frees, and refuses further requests meanwhile.
//   Reset empties the table and drops any pending response; RAM contents are
//   not cleared and are only read below the occupancy count.
module sorted_array_priority_queue import sapq_pkg::*; #(
    parameter int DEPTH = SAPQ_DEPTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    sapq_req_if.sink   i_req,
    sapq_rsp_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    sapq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.data.req_type),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sapq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_req.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data),
        .i_rsp_ready (o_rsp.ready)
    );

endmodule
